FILE: src/hdu_pkg.sv
`default_nettype none

package hdu_pkg;

    // angle pipeline sizes and word widths
    localparam int ANGLE_STEPS_DEF = 24;
    localparam int TAB_LEN         = 40;
    localparam int ANG_W           = 34;   // CORDIC x, y and z
    localparam int TRIG_W          = 32;   // sine and cosine, Q30
    localparam int ROOT_W          = 31;   // square root result
    localparam int SQ_IN_W         = 61;   // square root operand
    localparam int REM_W           = 62;   // square root remainder

    localparam logic [ANG_W-1:0] GAIN_Q30 = ANG_W'(652032874);
    localparam logic [29:0]      PI_Q28   = 30'd843314857;
    localparam logic [25:0]      DIST_MAX = 26'd67108863;
    localparam logic [23:0]      RADIUS_RESET = 24'd6523904;

    // degree to binary angle: offset keeps the operand positive,
    // the offset quotient drops out modulo a full turn
    localparam logic [30:0] TURN_OFFSET = 31'd1509949440;   // 90 * 2^24
    localparam logic [31:0] DIV_M       = 32'd3054198967;   // ceil(2^38 / 90)
    localparam int          DIV_SHIFT   = 38;
    localparam logic [16:0] FRAC_M      = 17'd93207;        // ceil(2^23 / 90)

    // arctangent of 2^-i in binary angle units
    function automatic logic [29:0] atan_entry(input int idx);
        logic [29:0] v;
        case (idx)
            0:  v = 30'd536870912;
            1:  v = 30'd316933406;
            2:  v = 30'd167458907;
            3:  v = 30'd85004756;
            4:  v = 30'd42667331;
            5:  v = 30'd21354465;
            6:  v = 30'd10679838;
            7:  v = 30'd5340245;
            8:  v = 30'd2670163;
            9:  v = 30'd1335087;
            10: v = 30'd667544;
            11: v = 30'd333772;
            12: v = 30'd166886;
            13: v = 30'd83443;
            14: v = 30'd41722;
            15: v = 30'd20861;
            16: v = 30'd10430;
            17: v = 30'd5215;
            18: v = 30'd2608;
            19: v = 30'd1304;
            20: v = 30'd652;
            21: v = 30'd326;
            22: v = 30'd163;
            23: v = 30'd81;
            24: v = 30'd41;
            25: v = 30'd20;
            26: v = 30'd10;
            27: v = 30'd5;
            28: v = 30'd3;
            29: v = 30'd1;
            30: v = 30'd1;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

    // floor((rem * 2^k + 45) / 90), k = 10 for whole, 9 for half angles
    function automatic logic [10:0] frac_turn(input logic [6:0] rem, input logic half);
        logic [16:0] v;
        logic [33:0] p;
        v = half ? (17'({rem, 9'b0}) + 17'd45) : (17'({rem, 10'b0}) + 17'd45);
        p = 34'(v) * 34'(FRAC_M);
        return p[33:23];
    endfunction

endpackage

`default_nettype wire

FILE: src/haversine_distance_unit.sv
`default_nettype none

// Great-circle distance by the haversine formula, fully pipelined: one point
// pair may enter every clock while the pipeline is not held, and one distance
// leaves per pair, in order. The path runs through the four rotation CORDICs,
// the two 31-stage square roots and the vectoring CORDIC. Every stage holds
// while the output skid register is occupied. The user must write the sphere
// radius through the configuration port only while no pair is in flight; the
// block itself does not enforce this.
module haversine_distance_unit import hdu_pkg::*; #(
    parameter int ANGLE_STEPS = ANGLE_STEPS_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    // config: sphere_radius
    input  wire logic         i_cfg_wen,
    input  wire logic [23:0]  i_cfg_wdata,
    // input stream
    input  wire logic         i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    // [27:0] first_latitude, [56:28] first_longitude,
    // [84:57] second_latitude, [113:85] second_longitude, [119:114] zero
    input  wire logic [119:0] i_s_axis_tdata,
    // output stream
    output logic              o_m_axis_tvalid,
    input  wire logic         i_m_axis_tready,
    // [25:0] distance, [31:26] zero
    output logic [31:0]       o_m_axis_tdata
);

    localparam int NANG = 4;

    logic        en;
    logic [23:0] r_radius;

    // input angles and differences
    logic signed [27:0] w_lat1, w_lat2;
    logic signed [28:0] w_lon1, w_lon2;
    logic signed [30:0] w_ang [NANG];

    logic        r_a_v, r_b_v, r_c_v, r_d_v;
    logic [30:0] r_a_ang  [NANG];
    logic [30:0] r_b_ang  [NANG];
    logic [62:0] r_b_prod [NANG];
    logic [24:0] r_c_q    [NANG];
    logic [6:0]  r_c_rem  [NANG];
    logic [31:0] r_d_turn [NANG];

    // trig outputs
    logic                     w_trig_v;
    logic signed [TRIG_W-1:0] w_c1, w_c2, w_sl, w_sn;

    // haversine term
    logic                     r_e_v, r_f_v, r_g_v, r_h_v;
    logic signed [63:0]       r_e_sl2, r_e_sn2, r_e_cc;
    logic signed [63:0]       w_sl2_rnd, w_sn2_rnd, w_cc_rnd, w_m_rnd;
    logic signed [TRIG_W-1:0] r_f_sl2, r_f_sn2, r_f_cc;
    logic signed [TRIG_W-1:0] r_g_sl2;
    logic signed [63:0]       r_g_m;
    logic signed [TRIG_W:0]   w_a;
    logic [30:0]              r_h_a;

    // square roots
    logic                     w_r_v;
    logic [ROOT_W-1:0]        w_r;
    logic                     r_i_v, r_j_v;
    logic [ROOT_W-1:0]        r_i_r, r_j_r;
    logic [SQ_IN_W-1:0]       r_i_sq, r_j_val;
    logic                     w_w_v;
    logic [ROOT_W-1:0]        w_w;
    logic [ROOT_W-1:0]        w_w_r;

    // vectoring CORDIC
    logic signed [ANG_W-1:0]  r_vx [0:ANGLE_STEPS-1];
    logic signed [ANG_W-1:0]  r_vy [0:ANGLE_STEPS-1];
    logic signed [ANG_W-1:0]  r_vz [0:ANGLE_STEPS-1];
    logic signed [ANG_W-1:0]  c_vx [0:ANGLE_STEPS];
    logic signed [ANG_W-1:0]  c_vy [0:ANGLE_STEPS];
    logic signed [ANG_W-1:0]  c_vz [0:ANGLE_STEPS];
    logic [ANGLE_STEPS-1:0]   r_vv;

    // scaling and output
    logic [30:0]  w_zc;
    logic         r_k_v, r_l_v, r_m_v, r_n_v;
    logic [60:0]  r_k_p;
    logic [60:0]  w_rad_sum;
    logic [31:0]  r_l_rad;
    logic [55:0]  r_m_p;
    logic [56:0]  w_d_sum;
    logic [25:0]  r_n_d;
    logic [25:0]  r_out, r_sk;
    logic         r_out_v, r_sk_v;

    // whole pipeline moves unless the skid word is held
    assign en              = !r_sk_v;
    assign o_s_axis_tready = en;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= RADIUS_RESET;
        end else if (i_cfg_wen) begin
            r_radius <= i_cfg_wdata;
        end
    end

    // unpack and form the four angles
    assign w_lat1 = $signed(i_s_axis_tdata[27:0]);
    assign w_lon1 = $signed(i_s_axis_tdata[56:28]);
    assign w_lat2 = $signed(i_s_axis_tdata[84:57]);
    assign w_lon2 = $signed(i_s_axis_tdata[113:85]);

    assign w_ang[0] = 31'(w_lat1);
    assign w_ang[1] = 31'(w_lat2);
    assign w_ang[2] = 31'(w_lat1) - 31'(w_lat2);
    assign w_ang[3] = 31'(w_lon1) - 31'(w_lon2);

    // degrees to binary angle: divide by 90 by reciprocal, then scale the remainder by reciprocal
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < NANG; k++) begin
                r_a_ang[k]  <= $unsigned(w_ang[k]) + TURN_OFFSET;
                r_b_ang[k]  <= r_a_ang[k];
                r_b_prod[k] <= 63'(r_a_ang[k]) * 63'(DIV_M);
                r_c_q[k]    <= r_b_prod[k][62:DIV_SHIFT];
                r_c_rem[k]  <= 7'(r_b_ang[k] - 31'(r_b_prod[k][62:DIV_SHIFT]) * 31'd90);
                if (k < 2) begin
                    r_d_turn[k] <= 32'({r_c_q[k], 10'b0}) + 32'(frac_turn(r_c_rem[k], 1'b0));
                end else begin
                    r_d_turn[k] <= 32'({r_c_q[k], 9'b0}) + 32'(frac_turn(r_c_rem[k], 1'b1));
                end
            end
        end
    end

    // sine and cosine banks
    hdu_sincos #(.STEPS(ANGLE_STEPS)) u_trig_lat1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_d_v),
        .i_turn  (r_d_turn[0]),
        .o_valid (w_trig_v),
        .o_sin   (),
        .o_cos   (w_c1)
    );

    hdu_sincos #(.STEPS(ANGLE_STEPS)) u_trig_lat2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_d_v),
        .i_turn  (r_d_turn[1]),
        .o_valid (),
        .o_sin   (),
        .o_cos   (w_c2)
    );

    hdu_sincos #(.STEPS(ANGLE_STEPS)) u_trig_dlat (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_d_v),
        .i_turn  (r_d_turn[2]),
        .o_valid (),
        .o_sin   (w_sl),
        .o_cos   ()
    );

    hdu_sincos #(.STEPS(ANGLE_STEPS)) u_trig_dlon (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_d_v),
        .i_turn  (r_d_turn[3]),
        .o_valid (),
        .o_sin   (w_sn),
        .o_cos   ()
    );

    // Q30 rounding of products
    assign w_sl2_rnd = (r_e_sl2 + 64'sd536870912) >>> 30;
    assign w_sn2_rnd = (r_e_sn2 + 64'sd536870912) >>> 30;
    assign w_cc_rnd  = (r_e_cc  + 64'sd536870912) >>> 30;
    assign w_m_rnd   = (r_g_m   + 64'sd536870912) >>> 30;
    // the cosine product can be negative, so keep its sign
    assign w_a       = (TRIG_W+1)'(r_g_sl2) + (TRIG_W+1)'($signed(w_m_rnd[TRIG_W-1:0]));

    // haversine term a, clamped to [0, 1]
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_e_sl2 <= 64'(w_sl) * 64'(w_sl);
            r_e_sn2 <= 64'(w_sn) * 64'(w_sn);
            r_e_cc  <= 64'(w_c1) * 64'(w_c2);
            r_f_sl2 <= w_sl2_rnd[TRIG_W-1:0];
            r_f_sn2 <= w_sn2_rnd[TRIG_W-1:0];
            r_f_cc  <= w_cc_rnd[TRIG_W-1:0];
            r_g_sl2 <= r_f_sl2;
            r_g_m   <= 64'(r_f_cc) * 64'(r_f_sn2);
            if (w_a[TRIG_W]) begin
                r_h_a <= '0;
            end else if (w_a > (TRIG_W+1)'(33'sd1073741824)) begin
                r_h_a <= 31'h4000_0000;
            end else begin
                r_h_a <= w_a[30:0];
            end
        end
    end

    // r = sqrt(a), then w = sqrt(1 - r^2)
    hdu_isqrt #(.SIDE_W(1)) u_sqrt_r (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_h_v),
        .i_value ({r_h_a, 30'b0}),
        .i_side  (1'b0),
        .o_valid (w_r_v),
        .o_root  (w_r),
        .o_side  ()
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_i_r   <= w_r;
            r_i_sq  <= SQ_IN_W'(62'(w_r) * 62'(w_r));
            r_j_r   <= r_i_r;
            r_j_val <= (SQ_IN_W'(1) << 60) - r_i_sq;
        end
    end

    hdu_isqrt #(.SIDE_W(ROOT_W)) u_sqrt_w (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_j_v),
        .i_value (r_j_val),
        .i_side  (r_j_r),
        .o_valid (w_w_v),
        .o_root  (w_w),
        .o_side  (w_w_r)
    );

    // vectoring CORDIC: angle of (w, r)
    assign c_vx[0] = $signed(ANG_W'(w_w));
    assign c_vy[0] = $signed(ANG_W'(w_w_r));
    assign c_vz[0] = '0;

    for (genvar gi = 0; gi < ANGLE_STEPS; gi++) begin : g_vec
        localparam logic signed [ANG_W-1:0] AT = ANG_W'(atan_entry(gi));
        logic signed [ANG_W-1:0] w_dx;
        logic signed [ANG_W-1:0] w_dy;

        assign w_dx = c_vy[gi] >>> gi;
        assign w_dy = c_vx[gi] >>> gi;

        always_ff @(posedge i_clk) begin
            if (en) begin
                if (c_vy[gi] > 0) begin
                    r_vx[gi] <= c_vx[gi] + w_dx;
                    r_vy[gi] <= c_vy[gi] - w_dy;
                    r_vz[gi] <= c_vz[gi] + AT;
                end else begin
                    r_vx[gi] <= c_vx[gi] - w_dx;
                    r_vy[gi] <= c_vy[gi] + w_dy;
                    r_vz[gi] <= c_vz[gi] - AT;
                end
            end
        end

        assign c_vx[gi+1] = r_vx[gi];
        assign c_vy[gi+1] = r_vy[gi];
        assign c_vz[gi+1] = r_vz[gi];
    end

    // clamp z to [0, quarter turn]
    always_comb begin
        if (c_vz[ANGLE_STEPS][ANG_W-1]) begin
            w_zc = '0;
        end else if (c_vz[ANGLE_STEPS] > ANG_W'(32'h4000_0000)) begin
            w_zc = 31'h4000_0000;
        end else begin
            w_zc = c_vz[ANGLE_STEPS][30:0];
        end
    end

    assign w_rad_sum = r_k_p + 61'd134217728;
    assign w_d_sum   = 57'(r_m_p) + 57'd536870912;

    // central angle in radians, then scale by radius and saturate
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_k_p   <= 61'(w_zc) * 61'(PI_Q28);
            r_l_rad <= w_rad_sum[59:28];
            r_m_p   <= 56'(r_radius) * 56'(r_l_rad);
            if (w_d_sum[56:30] > 27'(DIST_MAX)) begin
                r_n_d <= DIST_MAX;
            end else begin
                r_n_d <= w_d_sum[55:30];
            end
        end
    end

    // valid bits of the stages in this module
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
            r_d_v <= 1'b0;
            r_e_v <= 1'b0;
            r_f_v <= 1'b0;
            r_g_v <= 1'b0;
            r_h_v <= 1'b0;
            r_i_v <= 1'b0;
            r_j_v <= 1'b0;
            r_vv  <= '0;
            r_k_v <= 1'b0;
            r_l_v <= 1'b0;
            r_m_v <= 1'b0;
            r_n_v <= 1'b0;
        end else if (en) begin
            r_a_v <= i_s_axis_tvalid;
            r_b_v <= r_a_v;
            r_c_v <= r_b_v;
            r_d_v <= r_c_v;
            r_e_v <= w_trig_v;
            r_f_v <= r_e_v;
            r_g_v <= r_f_v;
            r_h_v <= r_g_v;
            r_i_v <= w_r_v;
            r_j_v <= r_i_v;
            r_vv  <= {r_vv[ANGLE_STEPS-2:0], w_w_v};
            r_k_v <= r_vv[ANGLE_STEPS-1];
            r_l_v <= r_k_v;
            r_m_v <= r_l_v;
            r_n_v <= r_m_v;
        end
    end

    // output word and skid word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
            r_sk_v  <= 1'b0;
        end else if (!r_out_v || i_m_axis_tready) begin
            if (r_sk_v) begin
                r_out_v <= 1'b1;
                r_sk_v  <= 1'b0;
            end else begin
                r_out_v <= r_n_v;
            end
        end else if (r_n_v) begin
            r_sk_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_v || i_m_axis_tready) begin
            r_out <= r_sk_v ? r_sk : r_n_d;
        end else if (en) begin
            r_sk <= r_n_d;
        end
    end

    assign o_m_axis_tvalid = r_out_v;
    assign o_m_axis_tdata  = {6'b0, r_out};

endmodule

`default_nettype wire

FILE: src/hdu_sincos.sv
`default_nettype none

// Rotation CORDIC: binary angle in, Q30 sine and cosine out.
module hdu_sincos import hdu_pkg::*; #(
    parameter int STEPS = ANGLE_STEPS_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_en,
    input  wire logic                     i_valid,
    input  wire logic [31:0]              i_turn,
    output logic                          o_valid,
    output logic signed [TRIG_W-1:0]      o_sin,
    output logic signed [TRIG_W-1:0]      o_cos
);

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;
    localparam logic signed [ANG_W-1:0] HALF_Q = ANG_W'(32'h2000_0000);

    logic [31:0]              w_rot;
    logic [1:0]               r_q   [0:STEPS];
    logic signed [ANG_W-1:0]  r_z0;
    logic signed [ANG_W-1:0]  r_x   [0:STEPS-1];
    logic signed [ANG_W-1:0]  r_y   [0:STEPS-1];
    logic signed [ANG_W-1:0]  r_z   [0:STEPS-1];
    logic signed [ANG_W-1:0]  c_x   [0:STEPS];
    logic signed [ANG_W-1:0]  c_y   [0:STEPS];
    logic signed [ANG_W-1:0]  c_z   [0:STEPS];
    logic [STEPS+1:0]         r_v;
    logic signed [TRIG_W-1:0] r_sin;
    logic signed [TRIG_W-1:0] r_cos;
    logic signed [ANG_W-1:0]  n_negx;
    logic signed [ANG_W-1:0]  n_negy;

    // quadrant and residual angle
    assign w_rot = i_turn + 32'h2000_0000;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q[0] <= w_rot[31:30];
            r_z0   <= $signed({{(ANG_W-30){1'b0}}, w_rot[29:0]}) - HALF_Q;
        end
    end

    assign c_x[0] = $signed(GAIN_Q30);
    assign c_y[0] = '0;
    assign c_z[0] = r_z0;

    // one micro-rotation per stage
    for (genvar gi = 0; gi < STEPS; gi++) begin : g_step
        localparam logic signed [ANG_W-1:0] AT = ANG_W'(atan_entry(gi));
        logic signed [ANG_W-1:0] w_dx;
        logic signed [ANG_W-1:0] w_dy;

        assign w_dx = c_y[gi] >>> gi;
        assign w_dy = c_x[gi] >>> gi;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_q[gi+1] <= r_q[gi];
                if (!c_z[gi][ANG_W-1]) begin
                    r_x[gi] <= c_x[gi] - w_dx;
                    r_y[gi] <= c_y[gi] + w_dy;
                    r_z[gi] <= c_z[gi] - AT;
                end else begin
                    r_x[gi] <= c_x[gi] + w_dx;
                    r_y[gi] <= c_y[gi] - w_dy;
                    r_z[gi] <= c_z[gi] + AT;
                end
            end
        end

        assign c_x[gi+1] = r_x[gi];
        assign c_y[gi+1] = r_y[gi];
        assign c_z[gi+1] = r_z[gi];
    end

    assign n_negx = -c_x[STEPS];
    assign n_negy = -c_y[STEPS];

    // map back to the full circle
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            unique case (r_q[STEPS])
                QUAD_0: begin
                    r_cos <= c_x[STEPS][TRIG_W-1:0];
                    r_sin <= c_y[STEPS][TRIG_W-1:0];
                end
                QUAD_1: begin
                    r_cos <= n_negy[TRIG_W-1:0];
                    r_sin <= c_x[STEPS][TRIG_W-1:0];
                end
                QUAD_2: begin
                    r_cos <= n_negx[TRIG_W-1:0];
                    r_sin <= n_negy[TRIG_W-1:0];
                end
                QUAD_3: begin
                    r_cos <= c_y[STEPS][TRIG_W-1:0];
                    r_sin <= n_negx[TRIG_W-1:0];
                end
                default: begin
                    r_cos <= c_x[STEPS][TRIG_W-1:0];
                    r_sin <= c_y[STEPS][TRIG_W-1:0];
                end
            endcase
        end
    end

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[STEPS:0], i_valid};
        end
    end

    assign o_valid = r_v[STEPS+1];
    assign o_sin   = r_sin;
    assign o_cos   = r_cos;

endmodule

`default_nettype wire

FILE: src/hdu_isqrt.sv
`default_nettype none

// Pipelined integer square root, one result bit per stage.
// A side word rides along unchanged.
module hdu_isqrt import hdu_pkg::*; #(
    parameter int SIDE_W = 1
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_en,
    input  wire logic               i_valid,
    input  wire logic [SQ_IN_W-1:0] i_value,
    input  wire logic [SIDE_W-1:0]  i_side,
    output logic                    o_valid,
    output logic [ROOT_W-1:0]       o_root,
    output logic [SIDE_W-1:0]       o_side
);

    localparam logic [REM_W-1:0]  REM_ONE  = REM_W'(1);
    localparam logic [ROOT_W-1:0] ROOT_ONE = ROOT_W'(1);

    logic [REM_W-1:0]  r_rem  [0:ROOT_W-1];
    logic [ROOT_W-1:0] r_root [0:ROOT_W-1];
    logic [SIDE_W-1:0] r_side [0:ROOT_W-1];
    logic [REM_W-1:0]  c_rem  [0:ROOT_W];
    logic [ROOT_W-1:0] c_root [0:ROOT_W];
    logic [SIDE_W-1:0] c_side [0:ROOT_W];
    logic [ROOT_W-1:0] r_v;

    assign c_rem[0]  = REM_W'(i_value);
    assign c_root[0] = '0;
    assign c_side[0] = i_side;

    for (genvar gk = 0; gk < ROOT_W; gk++) begin : g_bit
        localparam int B = ROOT_W - 1 - gk;
        logic [REM_W-1:0] w_trial;

        // remainder must cover (2*root + bit) * bit
        assign w_trial = (REM_W'(c_root[gk]) << (B + 1)) + (REM_ONE << (2 * B));

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_side[gk] <= c_side[gk];
                if (c_rem[gk] >= w_trial) begin
                    r_rem[gk]  <= c_rem[gk] - w_trial;
                    r_root[gk] <= c_root[gk] | (ROOT_ONE << B);
                end else begin
                    r_rem[gk]  <= c_rem[gk];
                    r_root[gk] <= c_root[gk];
                end
            end
        end

        assign c_rem[gk+1]  = r_rem[gk];
        assign c_root[gk+1] = r_root[gk];
        assign c_side[gk+1] = r_side[gk];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[ROOT_W-2:0], i_valid};
        end
    end

    assign o_valid = r_v[ROOT_W-1];
    assign o_root  = c_root[ROOT_W];
    assign o_side  = c_side[ROOT_W];

endmodule

`default_nettype wire
